### design/rsas_pkg.sv
`default_nettype none

package rsas_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W = 7;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_SEARCH = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [VALUE_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } out_word_t;

endpackage

`default_nettype wire

### design/rsas_store.sv
`default_nettype none

module rsas_store #(
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                                aclk,
    input  wire logic                                wr_en,
    input  wire logic [AW-1:0]                       wr_addr,
    input  wire logic signed [rsas_pkg::VALUE_W-1:0] wr_data,
    input  wire logic                                rd_en,
    input  wire logic [AW-1:0]                       rd_addr,
    output logic signed [rsas_pkg::VALUE_W-1:0]      rd_data
);

    logic signed [rsas_pkg::VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### design/rsas_seq.sv
`default_nettype none

module rsas_seq #(
    parameter int MAX_ELEMENTS = 128,
    localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1,
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1),
    localparam int PW = IW + 2
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire rsas_pkg::in_word_t                  s_word,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output rsas_pkg::out_word_t                      m_word,
    output logic                                     wr_en,
    output logic [IW-1:0]                            wr_addr,
    output logic signed [rsas_pkg::VALUE_W-1:0]      wr_data,
    output logic                                     rd_en,
    output logic [IW-1:0]                            rd_addr,
    input  wire logic signed [rsas_pkg::VALUE_W-1:0] rd_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PIV,
        S_PVT,
        S_BS,
        S_FIN
    } state_t;

    localparam logic signed [PW-1:0] ONE = PW'(1);
    localparam logic signed [PW-1:0] ZERO = '0;

    state_t                              state_reg, state_next;
    logic signed [PW-1:0]                lo_reg, lo_next;
    logic signed [PW-1:0]                hi_reg, hi_next;
    logic signed [PW-1:0]                mid_reg, mid_next;
    logic signed [rsas_pkg::VALUE_W-1:0] key_reg, key_next;
    logic signed [rsas_pkg::VALUE_W-1:0] elem0_reg, elem0_next;
    logic signed [rsas_pkg::VALUE_W-1:0] last_reg, last_next;
    logic [CNT_W-1:0]                    count_reg, count_next;
    logic                                found_reg, found_next;
    logic [rsas_pkg::POS_W-1:0]          pos_reg, pos_next;
    logic                                m_valid_reg, m_valid_next;
    rsas_pkg::out_word_t                 m_word_reg, m_word_next;
    logic signed [PW-1:0]                lo_t, hi_t;
    logic signed [PW-1:0]                cnt_s;

    assign cnt_s   = $signed(PW'(count_reg));
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;
    assign wr_addr = count_reg[IW-1:0];
    assign wr_data = s_word.value;
    assign rd_addr = mid_next[IW-1:0];

    always_comb begin
        state_next   = state_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        key_next     = key_reg;
        elem0_next   = elem0_reg;
        last_next    = last_reg;
        count_next   = count_reg;
        found_next   = found_reg;
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_word_next  = m_word_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        lo_t         = lo_reg;
        hi_t         = hi_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_word.mode == rsas_pkg::MODE_APPEND) begin
                        if (count_reg < CNT_W'(MAX_ELEMENTS)) begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            last_next  = s_word.value;
                            if (count_reg == '0) begin
                                elem0_next = s_word.value;
                            end
                        end
                    end else if (s_word.mode == rsas_pkg::MODE_CLEAR) begin
                        count_next = '0;
                    end else if (s_word.mode == rsas_pkg::MODE_SEARCH) begin
                        key_next = s_word.value;
                        if (count_reg == '0) begin
                            found_next = 1'b0;
                            pos_next   = '0;
                            state_next = S_FIN;
                        end else begin
                            lo_next = ZERO;
                            hi_next = cnt_s - ONE;
                            rd_en   = 1'b1;
                            if (cnt_s > ONE) begin
                                mid_next   = (cnt_s - ONE) >>> 1;
                                state_next = S_PIV;
                            end else begin
                                mid_next   = ZERO;
                                state_next = S_PVT;
                            end
                        end
                    end
                end
            end
            S_PIV: begin
                if (rd_data >= elem0_reg) begin
                    lo_t = mid_reg + ONE;
                    hi_t = hi_reg;
                end else begin
                    lo_t = lo_reg;
                    hi_t = mid_reg;
                end
                lo_next = lo_t;
                hi_next = hi_t;
                rd_en   = 1'b1;
                if (lo_t < hi_t) begin
                    mid_next = (lo_t + hi_t) >>> 1;
                end else begin
                    mid_next   = lo_t;
                    state_next = S_PVT;
                end
            end
            S_PVT: begin
                if (key_reg >= rd_data && key_reg <= last_reg) begin
                    lo_t = mid_reg;
                    hi_t = cnt_s - ONE;
                end else begin
                    lo_t = ZERO;
                    hi_t = mid_reg - ONE;
                end
                lo_next = lo_t;
                hi_next = hi_t;
                if (lo_t <= hi_t) begin
                    mid_next   = (lo_t + hi_t) >>> 1;
                    rd_en      = 1'b1;
                    state_next = S_BS;
                end else begin
                    found_next = 1'b0;
                    pos_next   = '0;
                    state_next = S_FIN;
                end
            end
            S_BS: begin
                if (rd_data == key_reg) begin
                    found_next = 1'b1;
                    pos_next   = rsas_pkg::POS_W'(mid_reg[IW-1:0]);
                    state_next = S_FIN;
                end else begin
                    if (key_reg > rd_data) begin
                        lo_t = mid_reg + ONE;
                        hi_t = hi_reg;
                    end else begin
                        lo_t = lo_reg;
                        hi_t = mid_reg - ONE;
                    end
                    lo_next = lo_t;
                    hi_next = hi_t;
                    if (lo_t <= hi_t) begin
                        mid_next = (lo_t + hi_t) >>> 1;
                        rd_en    = 1'b1;
                    end else begin
                        found_next = 1'b0;
                        pos_next   = '0;
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next         = 1'b1;
                    m_word_next.found    = found_reg;
                    m_word_next.position = pos_reg;
                    state_next           = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        key_reg    <= key_next;
        elem0_reg  <= elem0_next;
        last_reg   <= last_next;
        found_reg  <= found_next;
        pos_reg    <= pos_next;
        m_word_reg <= m_word_next;
    end

endmodule

`default_nettype wire

### design/rotated_sorted_array_search.sv
// Searches a rotated ascending array of distinct signed 32-bit values held in a
// single-port-read synchronous memory. An append word writes one element while the
// store holds fewer than MAX_ELEMENTS, and a clear word empties the store; neither
// gives a result. A search word first binary-searches for the rotation pivot and
// then binary-searches the half that can hold the key, one memory read per step,
// with the read data registered in the element memory. Each search gives exactly
// one result word, which waits in an output register while the next input word
// is accepted.

`default_nettype none

module rotated_sorted_array_search #(
    parameter int MAX_ELEMENTS = 128
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire rsas_pkg::in_word_t  s_word,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output rsas_pkg::out_word_t      m_word
);

    localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    logic                                wr_en;
    logic [IW-1:0]                       wr_addr;
    logic signed [rsas_pkg::VALUE_W-1:0] wr_data;
    logic                                rd_en;
    logic [IW-1:0]                       rd_addr;
    logic signed [rsas_pkg::VALUE_W-1:0] rd_data;

    rsas_seq #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rsas_store #(
        .DEPTH(MAX_ELEMENTS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rd_en && wr_en))
        else $error("Memory read and write issued in the same cycle.");

    a_write_on_append: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (s_valid && s_ready && s_word.mode == rsas_pkg::MODE_APPEND))
        else $error("Memory write without an accepted append word.");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid high after reset.");

endmodule

`default_nettype wire

### verif/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD = 4;
    localparam int RESET_CYCLES = 11;
    localparam int MAX_ELEMENTS = 128;
    localparam int ITEM_GOAL = 1450;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam longint TIMEOUT_NS = 3_000_000;
    localparam int NOT_FOUND = -1;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        rsas_pkg::in_word_t  word;
        bit                  typed;
        rsas_pkg::out_word_t want;
    } stim_row_t;

    localparam int OPENING_COUNT = 24;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    rsas_pkg::in_word_t  s_word;
    logic                m_valid;
    logic                m_ready = 1'b0;
    rsas_pkg::out_word_t m_word;

    int                  shadow_elems [MAX_ELEMENTS];
    int                  shadow_count = 0;
    rsas_pkg::out_word_t pending_results [$];
    int                  fail_count = 0;
    int                  sent_items = 0;
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    bit                  hold_go = 1'b0;
    logic                hold_active = 1'b0;

    stim_row_t opening_rows [OPENING_COUNT] = '{
        '{'{rsas_pkg::MODE_SEARCH, 32'sd0},            1'b1, '{1'b0, 7'd0}},
        '{'{rsas_pkg::MODE_SEARCH, 32'sh8000_0000},    1'b1, '{1'b0, 7'd0}},
        '{'{rsas_pkg::MODE_APPEND, 32'sd5},            1'b0, '{1'b0, 7'd0}},
        '{'{rsas_pkg::MODE_APPEND, 32'sd9},            1'b0, '{1'b0, 7'd0}},
        '{'{rsas_pkg::MODE_APPEND, 32'sh7FFF_FFFF},    1'b0, '{1'b0, 7'd0}},
        '{'{rsas_pkg::MODE_APPEND, 32'sh8000_0000},    1'b0, '{1'b0, 7'd0}},
        '{'{rsas_pkg::MODE_APPEND, -32'sd3},           1'b0, '{1'b0, 7'd0}},
        '{'{rsas_pkg::MODE_APPEND, 32'sd1},            1'b0, '{1'b0, 7'd0}},
        '{'{rsas_pkg::MODE_SEARCH, 32'sd5},            1'b1, '{1'b1, 7'd0}},
        '{'{rsas_pkg::MODE_SEARCH, 32'sh7FFF_FFFF},    1'b1, '{1'b1, 7'd2}},
        '{'{rsas_pkg::MODE_SEARCH, 32'sh8000_0000},    1'b1, '{1'b1, 7'd3}},
        '{'{rsas_pkg::MODE_SEARCH, 32'sd1},            1'b1, '{1'b1, 7'd5}},
        '{'{rsas_pkg::MODE_SEARCH, 32'sd4},            1'b1, '{1'b0, 7'd0}},
        '{'{MODE_UNUSED, 32'sh5555_AAAA},              1'b0, '{1'b0, 7'd0}},
        '{'{rsas_pkg::MODE_SEARCH, -32'sd3},           1'b0, '{1'b0, 7'd0}},
        '{'{rsas_pkg::MODE_SEARCH, -32'sd1},           1'b0, '{1'b0, 7'd0}},
        '{'{rsas_pkg::MODE_CLEAR,  32'sd0},            1'b0, '{1'b0, 7'd0}},
        '{'{rsas_pkg::MODE_SEARCH, 32'sd5},            1'b1, '{1'b0, 7'd0}},
        '{'{rsas_pkg::MODE_APPEND, -32'sd1},           1'b0, '{1'b0, 7'd0}},
        '{'{rsas_pkg::MODE_SEARCH, -32'sd1},           1'b1, '{1'b1, 7'd0}},
        '{'{rsas_pkg::MODE_APPEND, 32'sd3},            1'b0, '{1'b0, 7'd0}},
        '{'{rsas_pkg::MODE_APPEND, 32'sd2},            1'b0, '{1'b0, 7'd0}},
        '{'{rsas_pkg::MODE_SEARCH, 32'sd2},            1'b0, '{1'b0, 7'd0}},
        '{'{rsas_pkg::MODE_CLEAR,  -32'sd1},           1'b0, '{1'b0, 7'd0}}
    };

    rotated_sorted_array_search #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic int locate_pivot(input int count);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = count - 1;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_elems[mid] >= shadow_elems[0]) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    function automatic int span_search(input int lo_in, input int hi_in, input int key);
        int lo;
        int hi;
        int mid;
        lo = lo_in;
        hi = hi_in;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_elems[mid] == key) begin
                return mid;
            end
            if (key > shadow_elems[mid]) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        return NOT_FOUND;
    endfunction

    function automatic void apply_word(input rsas_pkg::in_word_t w, output bit has_res,
                                       output rsas_pkg::out_word_t res);
        int key;
        int last;
        int pivot;
        int idx;
        has_res = 1'b0;
        res = '0;
        key = int'(w.value);
        case (w.mode)
            rsas_pkg::MODE_APPEND: begin
                if (shadow_count < MAX_ELEMENTS) begin
                    shadow_elems[shadow_count] = key;
                    shadow_count++;
                end
            end
            rsas_pkg::MODE_CLEAR: begin
                shadow_count = 0;
            end
            rsas_pkg::MODE_SEARCH: begin
                has_res = 1'b1;
                if (shadow_count > 0) begin
                    last = shadow_count - 1;
                    pivot = locate_pivot(shadow_count);
                    if (key >= shadow_elems[pivot] && key <= shadow_elems[last]) begin
                        idx = span_search(pivot, last, key);
                    end else begin
                        idx = span_search(0, pivot - 1, key);
                    end
                    if (idx != NOT_FOUND) begin
                        res.found = 1'b1;
                        res.position = idx[rsas_pkg::POS_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    task automatic send_word(input logic [1:0] mode, input int value, input bit typed,
                             input rsas_pkg::out_word_t typed_res);
        rsas_pkg::in_word_t  w;
        bit                  has_res;
        rsas_pkg::out_word_t res;
        w.mode = mode;
        w.value = value;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_word(w, has_res, res);
        if (has_res) begin
            pending_results.push_back(typed ? typed_res : res);
        end
        if (mode != MODE_UNUSED) begin
            sent_items++;
        end
    endtask

    // One clear, a fill that is mostly a rotated ascending run, then searches.
    task automatic run_sequence();
        int          n;
        int          stored;
        int          rot;
        int          nsearch;
        int          r;
        int          key;
        bit          disorder;
        int unsigned span;
        longint      cur;
        int          ascend [$];
        int          vals [$];
        r = $urandom_range(0, 99);
        if (r < 6) begin
            n = $urandom_range(120, 136);
        end else if (r < 12) begin
            n = 0;
        end else begin
            n = $urandom_range(1, 20);
        end
        disorder = ($urandom_range(0, 99) < 15);
        if ($urandom_range(0, 1)) begin
            span = $urandom_range(0, 3);
            cur = -64'sd2147483648 + longint'($urandom_range(0, 32'hFFFF_F000));
        end else begin
            span = 32'hFFFF_FFFF / (n + 1) - 1;
            cur = -64'sd2147483648 + longint'($urandom_range(0, span));
        end
        for (int i = 0; i < n; i++) begin
            ascend.push_back(int'(cur));
            cur += 1 + longint'($urandom_range(0, span));
        end
        rot = (n > 0) ? $urandom_range(0, n - 1) : 0;
        for (int i = 0; i < n; i++) begin
            if (!disorder) begin
                vals.push_back(ascend[(i + rot) % n]);
            end else if ($urandom_range(0, 1)) begin
                vals.push_back(int'($urandom_range(0, 5)));
            end else begin
                vals.push_back(int'($urandom));
            end
        end
        stored = (n < MAX_ELEMENTS) ? n : MAX_ELEMENTS;

        send_word(rsas_pkg::MODE_CLEAR, int'($urandom), 1'b0, '0);
        for (int i = 0; i < n; i++) begin
            send_word(rsas_pkg::MODE_APPEND, vals[i], 1'b0, '0);
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_word(rsas_pkg::MODE_SEARCH, vals[$urandom_range(0, i)], 1'b0, '0);
            end else if (r < 11) begin
                send_word(MODE_UNUSED, int'($urandom), 1'b0, '0);
            end
        end
        nsearch = (n > 64) ? $urandom_range(10, 20) : $urandom_range(2, 8);
        for (int j = 0; j < nsearch; j++) begin
            r = $urandom_range(0, 99);
            if (stored > 0 && r < 60) begin
                key = vals[$urandom_range(0, stored - 1)];
            end else if (stored > 0 && r < 75) begin
                key = vals[$urandom_range(0, stored - 1)] + ($urandom_range(0, 1) ? 1 : -1);
            end else if (n > stored && r < 85) begin
                key = vals[$urandom_range(stored, n - 1)];
            end else begin
                key = int'($urandom);
            end
            send_word(rsas_pkg::MODE_SEARCH, key, 1'b0, '0);
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int goal);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        while (sent_items < goal) run_sequence();
    endtask

    always @(posedge aclk) begin : result_check
        rsas_pkg::out_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result word with none expected, found", m_word.found, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_word.found !== want.found) begin
                        report_mismatch("found", m_word.found, want.found);
                    end
                    if (m_word.position !== want.position) begin
                        report_mismatch("position", m_word.position, want.position);
                    end
                end
            end
            if (hold_active) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    initial begin : receiver_holdoff
        wait (hold_go);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_active <= 1'b0;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("rotated_sorted_array_search verification failed");
        $finish;
    end

    initial begin : stimulus
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_word = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (opening_rows[i]) begin
            send_word(opening_rows[i].word.mode, int'(opening_rows[i].word.value),
                      opening_rows[i].typed, opening_rows[i].want);
        end
        hold_go = 1'b1;
        run_phase(0, 0, ITEM_GOAL / 4);
        run_phase(52, 0, ITEM_GOAL / 2);
        run_phase(0, 52, 3 * ITEM_GOAL / 4);
        run_phase(37, 37, ITEM_GOAL);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("rotated_sorted_array_search verification clean");
        end else begin
            $display("rotated_sorted_array_search verification failed");
        end
        $finish;
    end

endmodule
